// ===== hw/rtl/sobmag_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
package sobmag_pkg;

    // Pixel and result widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 4;
    localparam int ROW_W   = 12;
    localparam int HEIGHT_LIMIT = 4096;

    // Gradients lie in -1020..1020, squares sum below 2^21
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 21;

    // Square root unit: 16-bit radicand, 8-bit root
    localparam int RAD_W   = 16;
    localparam int ROOT_W  = 8;
    localparam logic [RAD_W-1:0] RAD_TOP_BIT = 16'h4000;

    localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    // Per-pixel sequencer
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_GRAD   = 7'b0000100,
        S_SQUARE = 7'b0001000,
        S_RANGE  = 7'b0010000,
        S_ROOT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } seq_state_t;

endpackage

// ===== hw/rtl/sobmag_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module sobmag_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sobmag_pkg::RAD_W-1:0]   operand,
    output logic                           done,
    output logic [sobmag_pkg::ROOT_W-1:0]  root
);

    logic [sobmag_pkg::RAD_W-1:0] rem_reg,  rem_next;
    logic [sobmag_pkg::RAD_W-1:0] root_reg, root_next;
    logic [sobmag_pkg::RAD_W-1:0] bit_reg,  bit_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [sobmag_pkg::RAD_W:0]   trial;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    // Restoring step: subtract trial when it fits, shift the root
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = sobmag_pkg::RAD_TOP_BIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[sobmag_pkg::RAD_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // last step once the trial bit reaches the bottom
            if (bit_reg == {{(sobmag_pkg::RAD_W-1){1'b0}}, 1'b1})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[sobmag_pkg::ROOT_W-1:0];

endmodule

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// Sobel edge magnitude top level: line store, window, gradient and output stage.
//
// Pixels arrive in raster order, one beat at a time, and both previous rows are kept in a
// single line memory of MAX_WIDTH entries (upper and middle byte side by side) that is read
// when a pixel is taken and written back in the following cycle. A border pixel (first two
// rows or columns) gives no result. An interior pixel passes the read, gradient, square,
// range, root and output steps; the bit-per-cycle square root unit takes 8 steps, and
// the root step is skipped when the sum of squares saturates. Each interior pixel
// gives one result beat that carries the saturated magnitude and a flag on the last interior
// pixel of the frame. The result register lets the next pixel be taken while a result still
// waits; a later interior pixel holds in its output step until that beat is taken. The line
// memory needs no clearing after reset. Writing either register restarts the frame; widths
// and heights outside 3..MAX_WIDTH and 3..4096 are clamped.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pixel channel
    input  logic                                 pixel_valid,
    output logic                                 pixel_ready,
    input  logic [sobmag_pkg::PIX_W-1:0]         pixel,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [sobmag_pkg::PIX_W-1:0]         magnitude,
    output logic                                 last_of_frame,
    // configuration
    input  logic                                 cfg_write,
    input  logic [sobmag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobmag_pkg::CFG_W-1:0]         cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW    = sobmag_pkg::PIX_W;
    localparam int GW    = sobmag_pkg::GRAD_W;

    sobmag_pkg::seq_state_t state_reg, state_next;

    logic [sobmag_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0]             col_reg, last_col;
    logic [sobmag_pkg::ROW_W-1:0] row_reg, last_row;

    logic [PW-1:0]      px_reg;
    logic [2*PW-1:0]    rd_data_reg;
    logic [PW-1:0]      win_reg [3][3];
    logic               last_pend_reg;

    logic signed [GW-1:0]   gx_reg, gy_reg;
    logic signed [2*GW-1:0] gx_sq, gy_sq, sq_sum;
    logic [sobmag_pkg::SQ_W-1:0] sq_reg;
    logic [PW-1:0]          mag_reg;

    logic                   out_valid_reg;
    logic [PW-1:0]          out_mag_reg;
    logic                   out_last_reg;

    logic [2*PW-1:0]        line_mem [MAX_WIDTH];

    logic       accept, mem_we, out_free, emit, sqrt_start, sqrt_done;
    logic [sobmag_pkg::ROOT_W-1:0] sqrt_root;
    logic [31:0] width_ext, height_ext;

    function automatic logic signed [GW-1:0] widen(input logic [PW-1:0] p);
        widen = $signed({{(GW-PW){1'b0}}, p});
    endfunction

    assign accept   = pixel_valid && pixel_ready;
    assign mem_we   = (state_reg == sobmag_pkg::S_READ);
    assign out_free = !out_valid_reg || result_ready;
    assign emit     = (row_reg >= 12'd2) && (col_reg >= COL_W'(2));
    assign sqrt_start = (state_reg == sobmag_pkg::S_RANGE) && (sq_reg[sobmag_pkg::SQ_W-1:16] == '0);

    // Clamped frame geometry
    assign width_ext  = 32'(width_reg);
    assign height_ext = 32'(height_reg);
    always_comb
    begin
        priority if (width_ext < 32'd3)
            last_col = COL_W'(2);
        else if (width_ext > 32'(MAX_WIDTH))
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(width_ext - 32'd1);
        priority if (height_ext < 32'd3)
            last_row = sobmag_pkg::ROW_W'(2);
        else if (height_ext > 32'(sobmag_pkg::HEIGHT_LIMIT))
            last_row = sobmag_pkg::ROW_W'(sobmag_pkg::HEIGHT_LIMIT - 1);
        else
            last_row = sobmag_pkg::ROW_W'(height_ext - 32'd1);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sobmag_pkg::S_IDLE:
                if (accept)
                    state_next = sobmag_pkg::S_READ;
            sobmag_pkg::S_READ:
                state_next = emit ? sobmag_pkg::S_GRAD : sobmag_pkg::S_IDLE;
            sobmag_pkg::S_GRAD:
                state_next = sobmag_pkg::S_SQUARE;
            sobmag_pkg::S_SQUARE:
                state_next = sobmag_pkg::S_RANGE;
            sobmag_pkg::S_RANGE:
                state_next = sqrt_start ? sobmag_pkg::S_ROOT : sobmag_pkg::S_OUT;
            sobmag_pkg::S_ROOT:
                if (sqrt_done)
                    state_next = sobmag_pkg::S_OUT;
            sobmag_pkg::S_OUT:
                if (out_free)
                    state_next = sobmag_pkg::S_IDLE;
            default:
                state_next = sobmag_pkg::S_IDLE;
        endcase
    end

    assign pixel_ready = (state_reg == sobmag_pkg::S_IDLE);

    // Control state, counters, registers and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sobmag_pkg::S_IDLE;
            width_reg     <= 13'd4096;
            height_reg    <= 13'd4096;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // register write restarts the frame
            if (cfg_write && cfg_index == sobmag_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
                col_reg   <= '0;
                row_reg   <= '0;
            end
            else if (cfg_write && cfg_index == sobmag_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
                col_reg    <= '0;
                row_reg    <= '0;
            end
            else if (state_reg == sobmag_pkg::S_READ)
            begin
                if (col_reg == last_col)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == last_row) ? '0 : row_reg + 12'd1;
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end

            // window shifts left, new column from line memory and the pixel
            if (state_reg == sobmag_pkg::S_READ)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_data_reg[2*PW-1:PW];
                win_reg[1][2] <= rd_data_reg[PW-1:0];
                win_reg[2][2] <= px_reg;
            end

            // result register
            if (state_reg == sobmag_pkg::S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Line memory: upper byte is the row above the middle one
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[col_reg] <= {rd_data_reg[PW-1:0], px_reg};
        if (accept)
            rd_data_reg <= line_mem[col_reg];
    end

    // Gradient and square datapath
    assign gx_sq  = gx_reg * gx_reg;
    assign gy_sq  = gy_reg * gy_reg;
    assign sq_sum = gx_sq + gy_sq;

    always_ff @(posedge clk)
    begin
        if (accept)
            px_reg <= pixel;
        if (state_reg == sobmag_pkg::S_READ)
            last_pend_reg <= (row_reg == last_row) && (col_reg == last_col);
        if (state_reg == sobmag_pkg::S_GRAD)
        begin
            gx_reg <= (widen(win_reg[0][2]) - widen(win_reg[0][0]))
                    + ((widen(win_reg[1][2]) - widen(win_reg[1][0])) <<< 1)
                    + (widen(win_reg[2][2]) - widen(win_reg[2][0]));
            gy_reg <= widen(win_reg[0][0]) + (widen(win_reg[0][1]) <<< 1)
                    + widen(win_reg[0][2])
                    - widen(win_reg[2][0]) - (widen(win_reg[2][1]) <<< 1)
                    - widen(win_reg[2][2]);
        end
        if (state_reg == sobmag_pkg::S_SQUARE)
            sq_reg <= sq_sum[sobmag_pkg::SQ_W-1:0];
        // saturate large sums, otherwise take the root
        if (state_reg == sobmag_pkg::S_RANGE && !sqrt_start)
            mag_reg <= sobmag_pkg::MAG_SAT;
        else if (state_reg == sobmag_pkg::S_ROOT && sqrt_done)
            mag_reg <= sqrt_root;
        if (state_reg == sobmag_pkg::S_OUT && out_free)
        begin
            out_mag_reg  <= mag_reg;
            out_last_reg <= last_pend_reg;
        end
    end

    sobmag_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sq_reg[sobmag_pkg::RAD_W-1:0]),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign result_valid  = out_valid_reg;
    assign magnitude     = out_mag_reg;
    assign last_of_frame = out_last_reg;

endmodule
